@@ rtl/cfde_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and the cursor sprite for the clipped draw engine
package cfde_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int XW     = $clog2(MAX_WIDTH + 1);
  localparam int YW     = $clog2(MAX_HEIGHT + 1);
  localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int CFG_W  = 9;
  localparam int COORD_W = 18;

  localparam int ARROW_ROWS = 17;
  localparam int ARROW_COLS = 12;
  localparam int SIW = $clog2(ARROW_ROWS);
  localparam int SJW = $clog2(ARROW_COLS);

  localparam logic [31:0] ARROW_WHITE = 32'h00FF_FFFF;
  localparam logic [31:0] ARROW_BLACK = 32'h0000_0000;

  localparam logic [CFG_W-1:0] CFG_WIDTH_RESET  = 9'd256;
  localparam logic [CFG_W-1:0] CFG_HEIGHT_RESET = 9'd256;

  typedef enum logic [1:0] {
    OP_PIXEL  = 2'd0,
    OP_RECT   = 2'd1,
    OP_CURSOR = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    REG_ACTIVE_WIDTH  = 1'b0,
    REG_ACTIVE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    SP_T = 2'd0,
    SP_W = 2'd1,
    SP_K = 2'd2
  } spr_code_t;

  typedef struct packed {
    op_t                op;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] rect_w;
    logic signed [15:0] rect_h;
    logic        [31:0] pixel_color;
  } cmd_t;

  typedef struct packed {
    logic [31:0] read_color;
    logic        in_bounds;
  } res_t;

  localparam spr_code_t ARROW [ARROW_ROWS][ARROW_COLS] = '{
    '{SP_K, SP_K, SP_T, SP_T, SP_T, SP_T, SP_T, SP_T, SP_T, SP_T, SP_T, SP_T},
    '{SP_K, SP_W, SP_K, SP_T, SP_T, SP_T, SP_T, SP_T, SP_T, SP_T, SP_T, SP_T},
    '{SP_K, SP_W, SP_W, SP_K, SP_T, SP_T, SP_T, SP_T, SP_T, SP_T, SP_T, SP_T},
    '{SP_K, SP_W, SP_W, SP_W, SP_K, SP_T, SP_T, SP_T, SP_T, SP_T, SP_T, SP_T},
    '{SP_K, SP_W, SP_W, SP_W, SP_W, SP_K, SP_T, SP_T, SP_T, SP_T, SP_T, SP_T},
    '{SP_K, SP_W, SP_W, SP_W, SP_W, SP_W, SP_K, SP_T, SP_T, SP_T, SP_T, SP_T},
    '{SP_K, SP_W, SP_W, SP_W, SP_W, SP_W, SP_W, SP_K, SP_T, SP_T, SP_T, SP_T},
    '{SP_K, SP_W, SP_W, SP_W, SP_W, SP_W, SP_W, SP_W, SP_K, SP_T, SP_T, SP_T},
    '{SP_K, SP_W, SP_W, SP_W, SP_W, SP_W, SP_W, SP_W, SP_W, SP_K, SP_T, SP_T},
    '{SP_K, SP_W, SP_W, SP_W, SP_W, SP_W, SP_W, SP_W, SP_W, SP_W, SP_K, SP_T},
    '{SP_K, SP_W, SP_W, SP_W, SP_W, SP_W, SP_K, SP_K, SP_K, SP_K, SP_K, SP_K},
    '{SP_K, SP_W, SP_W, SP_K, SP_W, SP_W, SP_K, SP_T, SP_T, SP_T, SP_T, SP_T},
    '{SP_K, SP_W, SP_K, SP_T, SP_K, SP_W, SP_W, SP_K, SP_T, SP_T, SP_T, SP_T},
    '{SP_K, SP_K, SP_T, SP_T, SP_K, SP_W, SP_W, SP_K, SP_T, SP_T, SP_T, SP_T},
    '{SP_T, SP_T, SP_T, SP_T, SP_T, SP_K, SP_W, SP_W, SP_K, SP_T, SP_T, SP_T},
    '{SP_T, SP_T, SP_T, SP_T, SP_T, SP_K, SP_W, SP_W, SP_K, SP_T, SP_T, SP_T},
    '{SP_T, SP_T, SP_T, SP_T, SP_T, SP_T, SP_K, SP_K, SP_T, SP_T, SP_T, SP_T}
  };

  function automatic spr_code_t arrow_code(input logic [SIW-1:0] si,
                                           input logic [SJW-1:0] sj);
    spr_code_t code;
    code = SP_T;
    if ((32'(si) < ARROW_ROWS) && (32'(sj) < ARROW_COLS)) begin
      code = ARROW[si][sj];
    end
    return code;
  endfunction

endpackage

@@ rtl/clipped_framebuffer_draw_engine.sv @@
`timescale 1ns / 1ps
// clipped framebuffer draw engine: pixel, rectangle fill, cursor blit and pixel read
// flow: a pixel, rect fill or cursor (17x12 box) is latched, clipped in ST_CLIP, then
//   walked in ST_DRAW one pixel a cycle via the single ram port; an empty box skips it
// read: ST_CLIP, ST_RD_ADDR, ST_RD_DATA registers data and done; off screen ends at ST_RD_ADDR
// reset: sync, clears the sequencer and done, width and height registers go to 256;
//   frame contents are not cleared. done cannot be stalled: one cycle, then gone
module clipped_framebuffer_draw_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  cfde_pkg::cmd_t     cmd,
  output logic               done,
  output cfde_pkg::res_t     result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  cfde_pkg::reg_idx_t cfg_index,
  input  logic [8:0]         cfg_data
);
  import cfde_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLIP,
    ST_DRAW,
    ST_RD_ADDR,
    ST_RD_DATA
  } state_t;

  state_t state;

  // configuration
  logic [CFG_W-1:0] active_width;
  logic [CFG_W-1:0] active_height;
  logic [XW-1:0]    w_eff;
  logic [YW-1:0]    h_eff;

  // latched command and clipped box
  cmd_t             cmd_q;
  logic [XW-1:0]    x0, x1;
  logic [YW-1:0]    y1;
  logic [XW-1:0]    col;
  logic [YW-1:0]    row;
  logic [SJW-1:0]   sj, sj0;
  logic [SIW-1:0]   si;

  // clip arithmetic
  logic signed [COORD_W-1:0] xs, ys, ext_w, ext_h, xe, ye;
  logic signed [COORD_W-1:0] x0s, y0s, x1s, y1s, w_s, h_s;
  logic                      box_ok;
  logic [SJW-1:0]            sj_start;
  logic [SIW-1:0]            si_start;

  // ram port
  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_addr;
  logic [31:0]               ram_wdata;
  logic [31:0]               ram_rdata;
  logic [YW+XW-1:0]          row_prod;
  logic [YW+XW-1:0]          addr_sum;
  spr_code_t                 code;
  logic [XW-1:0]             col_inc;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);

  // saturate the screen size to the store geometry
  assign w_eff = (32'(active_width) > MAX_WIDTH)  ? XW'(MAX_WIDTH)  : XW'(active_width);
  assign h_eff = (32'(active_height) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(active_height);
  assign w_s   = COORD_W'($signed({1'b0, w_eff}));
  assign h_s   = COORD_W'($signed({1'b0, h_eff}));

  // one box shape for every command: a pixel or read is a 1x1 box, the cursor its sprite box
  always_comb begin
    xs = COORD_W'(cmd_q.pos_x);
    ys = COORD_W'(cmd_q.pos_y);
    case (cmd_q.op)
      OP_RECT: begin
        ext_w = COORD_W'(cmd_q.rect_w);
        ext_h = COORD_W'(cmd_q.rect_h);
      end
      OP_CURSOR: begin
        ext_w = COORD_W'(ARROW_COLS);
        ext_h = COORD_W'(ARROW_ROWS);
      end
      default: begin
        ext_w = COORD_W'(1);
        ext_h = COORD_W'(1);
      end
    endcase
    xe  = xs + ext_w;
    ye  = ys + ext_h;
    x0s = (xs < 0) ? '0 : xs;
    y0s = (ys < 0) ? '0 : ys;
    x1s = (xe > w_s) ? w_s : xe;
    y1s = (ye > h_s) ? h_s : ye;
    box_ok   = (x0s < x1s) && (y0s < y1s);
    sj_start = SJW'(x0s - xs);
    si_start = SIW'(y0s - ys);
  end

  // row-major address; row and col stay inside the box during the draw walk
  assign row_prod = row * w_eff;
  assign addr_sum = row_prod + (YW + XW)'(col);
  assign ram_addr = addr_sum[ADDR_W-1:0];

  assign code      = arrow_code(si, sj);
  assign ram_we    = (state == ST_DRAW) && ((cmd_q.op != OP_CURSOR) || (code != SP_T));
  assign ram_wdata = (cmd_q.op != OP_CURSOR) ? cmd_q.pixel_color :
                     (code == SP_W)          ? ARROW_WHITE : ARROW_BLACK;
  assign col_inc   = col + XW'(1);

  cfde_ram #(
    .WIDTH (32),
    .DEPTH (MAX_WIDTH * MAX_HEIGHT)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      done          <= 1'b0;
      active_width  <= CFG_WIDTH_RESET;
      active_height <= CFG_HEIGHT_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ACTIVE_WIDTH:  active_width  <= cfg_data;
          REG_ACTIVE_HEIGHT: active_height <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            state <= ST_CLIP;
          end
        end
        ST_CLIP: begin
          // box corners fit the store once known non-empty
          x0  <= x0s[XW-1:0];
          x1  <= x1s[XW-1:0];
          y1  <= y1s[YW-1:0];
          col <= x0s[XW-1:0];
          row <= y0s[YW-1:0];
          sj  <= sj_start;
          sj0 <= sj_start;
          si  <= si_start;
          if (cmd_q.op == OP_READ) begin
            state <= ST_RD_ADDR;
          end else if (box_ok) begin
            state <= ST_DRAW;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_DRAW: begin
          // raster walk of the clipped box, one pixel per cycle
          if (col_inc == x1) begin
            col <= x0;
            sj  <= sj0;
            if ((row + YW'(1)) == y1) begin
              state <= ST_IDLE;
            end else begin
              row <= row + YW'(1);
              si  <= si + SIW'(1);
            end
          end else begin
            col <= col_inc;
            sj  <= sj + SJW'(1);
          end
        end
        ST_RD_ADDR: begin
          // off-screen read answers at once with zeros
          if (box_ok) begin
            state <= ST_RD_DATA;
          end else begin
            result.read_color <= '0;
            result.in_bounds  <= 1'b0;
            done              <= 1'b1;
            state             <= ST_IDLE;
          end
        end
        ST_RD_DATA: begin
          result.read_color <= ram_rdata;
          result.in_bounds  <= 1'b1;
          done              <= 1'b1;
          state             <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a result only ever follows the read path
  a_done_from_read: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_RD_DATA) || ($past(state) == ST_RD_ADDR))
    else $error("done without a read");

  // off-screen reads return zero
  a_oob_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.in_bounds |-> result.read_color == '0)
    else $error("off-screen read returned data");

  // the write walk stays inside the clipped box
  a_walk_in_box: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAW |-> (col >= x0) && (col < x1) && (row < y1))
    else $error("draw walk left the box");

  // an accepted command makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("command accepted without going busy");

  // cursor walk never indexes outside the sprite
  a_sprite_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAW) && (cmd_q.op == OP_CURSOR) |->
      (32'(si) < ARROW_ROWS) && (32'(sj) < ARROW_COLS))
    else $error("cursor walk outside sprite");

endmodule

@@ rtl/cfde_ram.sv @@
`timescale 1ns / 1ps
// generic single-port synchronous ram with registered read
module cfde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
